>>> hw/rtl/http_header_line_tokenizer_defines.svh
// Assertion macros shared by the header line tokenizer RTL.
// No dependencies; included by the files that carry assertions.
`ifndef HTTP_HEADER_LINE_TOKENIZER_DEFINES_SVH
`define HTTP_HEADER_LINE_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define HHLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hhlt assertion failed");

// Next-cycle implication, disabled while reset is low.
`define HHLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hhlt assertion failed");

`endif

>>> hw/rtl/hhlt_pkg.sv
// Types, constants, byte classifier and transition table of the header tokenizer.
// No dependencies; used by every other RTL file of the block but the assertion macro header.
package hhlt_pkg;

    localparam logic [6:0]  MAX_HEADERS   = 7'd64;
    localparam logic [15:0] MAX_BYTES_RST = 16'd4096;

    localparam logic [3:0] ST_START = 4'd0;
    localparam logic [3:0] ST_KEY   = 4'd2;
    localparam logic [3:0] ST_DONE  = 4'd10;
    localparam logic [3:0] ST_ERR   = 4'd11;

    localparam int unsigned ACT_SPACE = 14;
    localparam int unsigned ACT_UNDO  = 13;
    localparam int unsigned ACT_TERM  = 12;
    localparam int unsigned ACT_CUT   = 11;
    localparam int unsigned ACT_PUT   = 8;

    localparam logic [2:0] CL_CTL   = 3'd0;
    localparam logic [2:0] CL_CR    = 3'd1;
    localparam logic [2:0] CL_LF    = 3'd2;
    localparam logic [2:0] CL_BLANK = 3'd3;
    localparam logic [2:0] CL_COLON = 3'd4;
    localparam logic [2:0] CL_SEP   = 3'd5;
    localparam logic [2:0] CL_TOKEN = 3'd6;
    localparam logic [2:0] CL_HIGH  = 3'd7;

    localparam logic [7:0] CHR_SPACE = 8'h20;

    typedef enum logic [2:0] {
        K_IDLE   = 3'd0,
        K_KEY    = 3'd1,
        K_VAL    = 3'd2,
        K_KEYEND = 3'd3,
        K_PAIR   = 3'd4,
        K_END    = 3'd5,
        K_BAD    = 3'd6,
        K_BIG    = 3'd7
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [6:0] hdr;
    } t_item;

    typedef struct packed {
        t_item it0;
        t_item it1;
        logic  two;
    } t_result;

    localparam logic [15:0] TRANS [10][8] = '{
        '{16'h000b, 16'h0001, 16'h000a, 16'h000b, 16'h000b, 16'h000b, 16'h0502, 16'h000b},
        '{16'h000b, 16'h000b, 16'h000a, 16'h000b, 16'h000b, 16'h000b, 16'h000b, 16'h000b},
        '{16'h000b, 16'h000b, 16'h000b, 16'h000b, 16'h1203, 16'h000b, 16'h0102, 16'h000b},
        '{16'h000b, 16'h0004, 16'h0005, 16'h0003, 16'h0106, 16'h0106, 16'h0106, 16'h0106},
        '{16'h000b, 16'h000b, 16'h0005, 16'h000b, 16'h000b, 16'h000b, 16'h000b, 16'h000b},
        '{16'h000b, 16'h1801, 16'h180a, 16'h0003, 16'h000b, 16'h000b, 16'h1d02, 16'h000b},
        '{16'h000b, 16'h4008, 16'h4009, 16'h4007, 16'h0106, 16'h0106, 16'h0106, 16'h0106},
        '{16'h000b, 16'h0008, 16'h0009, 16'h0007, 16'h0106, 16'h0106, 16'h0106, 16'h0106},
        '{16'h000b, 16'h000b, 16'h0009, 16'h000b, 16'h000b, 16'h000b, 16'h000b, 16'h000b},
        '{16'h000b, 16'h3801, 16'h380a, 16'h0007, 16'h000b, 16'h000b, 16'h3d02, 16'h000b}
    };

    function automatic logic [2:0] f_class(input logic [7:0] b);
        logic [2:0] cls;
        if (b[7]) begin
            cls = CL_HIGH;
        end else begin
            case (b) inside
                8'h0d: cls = CL_CR;
                8'h0a: cls = CL_LF;
                8'h20, 8'h09: cls = CL_BLANK;
                8'h3a: cls = CL_COLON;
                8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h5c,
                8'h22, 8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d: cls = CL_SEP;
                8'h7f: cls = CL_CTL;
                default: cls = (b < 8'h20) ? CL_CTL : CL_TOKEN;
            endcase
        end
        return cls;
    endfunction

endpackage

>>> hw/rtl/hhlt_ifs.sv
// Channel interfaces of the header tokenizer: byte input, item output, config write.
// Depends on hhlt_pkg for the item kind type.
interface hhlt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       start_req;
    modport source (output valid, output in_byte, output start_req, input ready);
    modport sink (input valid, input in_byte, input start_req, output ready);
endinterface

interface hhlt_out_if;
    logic               valid;
    logic               ready;
    hhlt_pkg::t_kind    kind;
    logic [7:0]         data_byte;
    logic [6:0]         header_count;
    logic               last;
    modport source (output valid, output kind, output data_byte, output header_count,
                    output last, input ready);
    modport sink (input valid, input kind, input data_byte, input header_count,
                  input last, output ready);
endinterface

interface hhlt_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_bytes;
    modport source (output valid, output max_bytes, input ready);
    modport sink (input valid, input max_bytes, output ready);
endinterface

>>> hw/rtl/http_header_line_tokenizer.sv
// HTTP header line tokenizer: usage notes below.
// Depends on hhlt_pkg, hhlt_ifs, hhlt_step and hhlt_out.
//
// Channels: i_byte_ch carries one header byte per transaction plus start_req, which
// restarts the block parse before that byte. o_item_ch carries one item per
// transaction (kind, data_byte, header_count, last); each byte yields one or two
// items, the final one marked by last. i_cfg_ch writes max_bytes and is always ready;
// write it only while no byte is in flight.
// Path: a byte passes the input register (hhlt_step) and then the result register
// (hhlt_out) before its first item is valid on o_item_ch.
// Throughput: one byte per cycle while each byte yields one item and o_item_ch.ready
// stays high; a byte with two items holds the output register until both are taken,
// since the single output register hands out one item per transaction.
// Reset: parse state, byte and header counters clear, max_bytes returns to 4096, both
// pipeline registers empty.
// Receiver stall: the output item holds; the input register still fills, then
// i_byte_ch.ready drops until the output drains.
module http_header_line_tokenizer (
    input logic       i_clk,
    input logic       i_rst_n,
    hhlt_in_if.sink   i_byte_ch,
    hhlt_out_if.source o_item_ch,
    hhlt_cfg_if.sink  i_cfg_ch
);
    import hhlt_pkg::*;

    logic [15:0] r_max_bytes;
    logic        res_valid;
    logic        res_ready;
    t_result     res;
    t_item       item;

    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= MAX_BYTES_RST;
        end else if (i_cfg_ch.valid) begin
            r_max_bytes <= i_cfg_ch.max_bytes;
        end
    end

    hhlt_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_byte_ch.valid),
        .o_in_ready  (i_byte_ch.ready),
        .i_in_byte   (i_byte_ch.in_byte),
        .i_start_req (i_byte_ch.start_req),
        .i_max_bytes (r_max_bytes),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    hhlt_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .o_res_ready (res_ready),
        .i_res       (res),
        .o_valid     (o_item_ch.valid),
        .i_ready     (o_item_ch.ready),
        .o_item      (item),
        .o_last      (o_item_ch.last)
    );

    assign o_item_ch.kind         = item.kind;
    assign o_item_ch.data_byte    = item.data;
    assign o_item_ch.header_count = item.hdr;

endmodule

>>> hw/rtl/hhlt_step.sv
// Input register, parse state and per-byte tokenizer logic producing one or two items.
// Depends on hhlt_pkg (table, classifier, item types).
module hhlt_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_in_byte,
    input  logic              i_start_req,
    input  logic [15:0]       i_max_bytes,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output hhlt_pkg::t_result o_res
);
    import hhlt_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_start;
    logic [3:0]  r_ps;
    logic [15:0] r_used;
    logic [6:0]  r_hdr;
    logic        r_pend;

    logic [3:0]  n_ps;
    logic [15:0] n_used;
    logic [6:0]  n_hdr;
    logic        n_pend;
    logic        move;

    function automatic void f_emit(input t_kind k, input logic [7:0] d, input logic [6:0] h,
                                   inout t_result r, inout logic [1:0] n);
        t_item it;
        it = '{kind: k, data: d, hdr: h};
        case (n)
            2'd0: r.it0 = it;
            2'd1: begin
                r.it1 = it;
                r.two = 1'b1;
            end
            default: ;
        endcase
        if (n != 2'd2) n = n + 2'd1;
    endfunction

    always_comb begin
        t_result    res;
        logic [1:0] cnt;
        logic       live;
        logic [15:0] code;
        logic [3:0] nxt;
        t_kind      pkind;
        res   = '0;
        cnt   = 2'd0;
        code  = '0;
        nxt   = '0;
        pkind = K_VAL;
        n_ps   = r_start ? ST_START : r_ps;
        n_used = r_start ? '0 : r_used;
        n_hdr  = r_start ? '0 : r_hdr;
        n_pend = r_start ? 1'b0 : r_pend;
        live   = (n_ps < ST_DONE);
        if (live) begin
            code = TRANS[n_ps][f_class(r_byte)];
            nxt  = code[3:0];
            n_ps = nxt;
            if (nxt == ST_ERR) begin
                f_emit(K_BAD, 8'd0, n_hdr, res, cnt);
                live = 1'b0;
            end
        end
        if (live && code[ACT_SPACE]) begin
            if (n_used >= i_max_bytes) begin
                n_ps = ST_ERR;
                f_emit(K_BIG, 8'd0, n_hdr, res, cnt);
                live = 1'b0;
            end else begin
                n_used = n_used + 16'd1;
                n_pend = 1'b1;
            end
        end
        if (live && code[ACT_UNDO] && n_pend) begin
            n_used = n_used - 16'd1;
            n_pend = 1'b0;
        end
        if (live && code[ACT_TERM]) begin
            if (n_used >= i_max_bytes) begin
                n_ps = ST_ERR;
                f_emit(K_BIG, 8'd0, n_hdr, res, cnt);
                live = 1'b0;
            end else begin
                n_used = n_used + 16'd1;
                if (!code[ACT_CUT]) f_emit(K_KEYEND, 8'd0, n_hdr, res, cnt);
            end
        end
        if (live && code[ACT_CUT]) begin
            if (n_hdr >= MAX_HEADERS) begin
                n_ps = ST_ERR;
                f_emit(K_BIG, 8'd0, n_hdr, res, cnt);
                live = 1'b0;
            end else begin
                n_hdr = n_hdr + 7'd1;
                f_emit(K_PAIR, 8'd0, n_hdr, res, cnt);
            end
        end
        if (live && code[ACT_PUT]) begin
            pkind = (nxt == ST_KEY) ? K_KEY : K_VAL;
            if (n_pend) begin
                f_emit(K_VAL, CHR_SPACE, n_hdr, res, cnt);
                n_pend = 1'b0;
            end
            if (n_used >= i_max_bytes) begin
                n_ps = ST_ERR;
                f_emit(K_BIG, 8'd0, n_hdr, res, cnt);
                live = 1'b0;
            end else begin
                n_used = n_used + 16'd1;
                f_emit(pkind, r_byte, n_hdr, res, cnt);
            end
        end
        if (live && nxt == ST_DONE) f_emit(K_END, 8'd0, n_hdr, res, cnt);
        if (cnt == 2'd0) f_emit(K_IDLE, 8'd0, n_hdr, res, cnt);
        o_res = res;
    end

    assign move        = r_in_valid && i_res_ready;
    assign o_in_ready  = !r_in_valid || i_res_ready;
    assign o_res_valid = r_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_ps       <= ST_START;
            r_used     <= '0;
            r_hdr      <= '0;
            r_pend     <= 1'b0;
        end else begin
            if (o_in_ready) r_in_valid <= i_in_valid;
            if (move) begin
                r_ps   <= n_ps;
                r_used <= n_used;
                r_hdr  <= n_hdr;
                r_pend <= n_pend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_byte  <= i_in_byte;
            r_start <= i_start_req;
        end
    end

endmodule

>>> hw/rtl/hhlt_out.sv
// Result register that hands out the one or two items of a byte as single transactions.
// Depends on hhlt_pkg and the assertion macro header.
`include "http_header_line_tokenizer_defines.svh"
module hhlt_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    output logic              o_res_ready,
    input  hhlt_pkg::t_result i_res,
    output logic              o_valid,
    input  logic              i_ready,
    output hhlt_pkg::t_item   o_item,
    output logic              o_last
);
    import hhlt_pkg::*;

    logic    r_valid;
    logic    r_idx;
    t_result r_res;
    logic    drain;

    assign o_valid     = r_valid;
    assign o_item      = r_idx ? r_res.it1 : r_res.it0;
    assign o_last      = r_idx || !r_res.two;
    assign drain       = r_valid && i_ready && o_last;
    assign o_res_ready = !r_valid || drain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else if (o_res_ready && i_res_valid) begin
            r_valid <= 1'b1;
            r_idx   <= 1'b0;
        end else if (drain) begin
            r_valid <= 1'b0;
        end else if (r_valid && i_ready) begin
            r_idx <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) r_res <= i_res;
    end

    `HHLT_ASSERT_IMP(a_idx_two, i_clk, i_rst_n, r_valid && r_idx, r_res.two)
    `HHLT_ASSERT_NXT(a_load_first, i_clk, i_rst_n, o_res_ready && i_res_valid,
                     r_valid && !r_idx)
    `HHLT_ASSERT_NXT(a_drain_empty, i_clk, i_rst_n, drain && !i_res_valid, !r_valid)
    `HHLT_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, r_valid && !i_ready,
                     r_valid && $stable(r_idx))

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of http_header_line_tokenizer: header byte streams are
// predicted by a behavioral tokenizer and checked item by item at the output.
// Depends on hhlt_pkg and the channel interfaces in hhlt_ifs.
module tb;
    import hhlt_pkg::*;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int CALM_TAIL        = 120;
    localparam int BYTE_TARGET      = 850;

    typedef enum logic [1:0] {OP_BYTE, OP_CFG, OP_DRAIN} t_op;

    typedef struct {
        t_op         op;
        logic [7:0]  data;
        logic        start;
        logic [15:0] cap;
    } t_pending;

    typedef struct {
        t_kind      kind;
        logic [7:0] data;
        logic [6:0] hdr;
        logic       last;
    } t_token;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hhlt_in_if  byte_ch ();
    hhlt_out_if item_ch ();
    hhlt_cfg_if cfg_ch ();

    http_header_line_tokenizer dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_ch (byte_ch),
        .o_item_ch (item_ch),
        .i_cfg_ch  (cfg_ch)
    );

    logic [15:0] step_tbl [10][8] = '{
        '{16'h000b, 16'h0001, 16'h000a, 16'h000b, 16'h000b, 16'h000b, 16'h0502, 16'h000b},
        '{16'h000b, 16'h000b, 16'h000a, 16'h000b, 16'h000b, 16'h000b, 16'h000b, 16'h000b},
        '{16'h000b, 16'h000b, 16'h000b, 16'h000b, 16'h1203, 16'h000b, 16'h0102, 16'h000b},
        '{16'h000b, 16'h0004, 16'h0005, 16'h0003, 16'h0106, 16'h0106, 16'h0106, 16'h0106},
        '{16'h000b, 16'h000b, 16'h0005, 16'h000b, 16'h000b, 16'h000b, 16'h000b, 16'h000b},
        '{16'h000b, 16'h1801, 16'h180a, 16'h0003, 16'h000b, 16'h000b, 16'h1d02, 16'h000b},
        '{16'h000b, 16'h4008, 16'h4009, 16'h4007, 16'h0106, 16'h0106, 16'h0106, 16'h0106},
        '{16'h000b, 16'h0008, 16'h0009, 16'h0007, 16'h0106, 16'h0106, 16'h0106, 16'h0106},
        '{16'h000b, 16'h000b, 16'h0009, 16'h000b, 16'h000b, 16'h000b, 16'h000b, 16'h000b},
        '{16'h000b, 16'h3801, 16'h380a, 16'h0007, 16'h000b, 16'h000b, 16'h3d02, 16'h000b}
    };

    logic [3:0]  prs_state = ST_START;
    logic [15:0] prs_used = '0;
    logic [6:0]  prs_hdrs = '0;
    logic        prs_space = 1'b0;
    logic [15:0] prs_cap = MAX_BYTES_RST;
    t_token      step_out [2];
    int          step_n;
    t_token      token_q [$];

    t_pending    pend_q [$];
    logic        next_start = 1'b0;
    int          byte_total = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          quiet_cycles = 0;
    int          idle_cycles = 0;
    int          errors = 0;
    bit          calm = 1'b0;

    function automatic logic [2:0] byte_group(input logic [7:0] b);
        if (b[7]) return CL_HIGH;
        case (b)
            CH_CR: return CL_CR;
            CH_LF: return CL_LF;
            CHR_SPACE, CH_TAB: return CL_BLANK;
            CH_COLON: return CL_COLON;
            "(", ")", "<", ">", "@", ",", ";", "\\", "\"", "/", "[", "]", "?", "=", "{", "}":
                return CL_SEP;
            default: return (b < 8'h20 || b == 8'h7f) ? CL_CTL : CL_TOKEN;
        endcase
    endfunction

    function automatic void add_token(input t_kind k, input logic [7:0] d);
        if (step_n < 2) begin
            step_out[step_n].kind = k;
            step_out[step_n].data = d;
            step_out[step_n].hdr  = prs_hdrs;
            step_out[step_n].last = 1'b0;
            step_n++;
        end
    endfunction

    function automatic bit take_slot();
        if (prs_used >= prs_cap) begin
            prs_state = ST_ERR;
            add_token(K_BIG, 8'h00);
            return 1'b0;
        end
        prs_used++;
        return 1'b1;
    endfunction

    task automatic tokenize(input logic [7:0] b);
        logic [15:0] code;
        if (prs_state >= ST_DONE) return;
        code = step_tbl[prs_state][byte_group(b)];
        prs_state = code[3:0];
        if (prs_state == ST_ERR) begin
            add_token(K_BAD, 8'h00);
            return;
        end
        if (code[ACT_SPACE]) begin
            if (!take_slot()) return;
            prs_space = 1'b1;
        end
        if (code[ACT_UNDO] && prs_space) begin
            prs_used--;
            prs_space = 1'b0;
        end
        if (code[ACT_TERM]) begin
            if (!take_slot()) return;
            if (!code[ACT_CUT]) add_token(K_KEYEND, 8'h00);
        end
        if (code[ACT_CUT]) begin
            if (prs_hdrs >= MAX_HEADERS) begin
                prs_state = ST_ERR;
                add_token(K_BIG, 8'h00);
                return;
            end
            prs_hdrs++;
            add_token(K_PAIR, 8'h00);
        end
        if (code[ACT_PUT]) begin
            if (prs_space) begin
                add_token(K_VAL, CHR_SPACE);
                prs_space = 1'b0;
            end
            if (!take_slot()) return;
            add_token((code[3:0] == ST_KEY) ? K_KEY : K_VAL, b);
        end
        if (code[3:0] == ST_DONE) add_token(K_END, 8'h00);
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic clr);
        step_n = 0;
        if (clr) begin
            prs_state = ST_START;
            prs_used  = '0;
            prs_hdrs  = '0;
            prs_space = 1'b0;
        end
        tokenize(b);
        if (step_n == 0) add_token(K_IDLE, 8'h00);
        step_out[step_n - 1].last = 1'b1;
        for (int i = 0; i < step_n; i++) token_q.push_back(step_out[i]);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    function automatic void push_byte(input logic [7:0] b);
        pend_q.push_back('{op: OP_BYTE, data: b, start: next_start, cap: 16'd0});
        next_start = 1'b0;
        byte_total++;
    endfunction

    function automatic void push_cfg(input logic [15:0] v);
        pend_q.push_back('{op: OP_CFG, data: 8'h00, start: 1'b0, cap: v});
    endfunction

    function automatic void push_drain();
        pend_q.push_back('{op: OP_DRAIN, data: 8'h00, start: 1'b0, cap: 16'd0});
    endfunction

    function automatic logic [7:0] pick_token();
        logic [7:0] b;
        do b = 8'($urandom_range(33, 126)); while (byte_group(b) != CL_TOKEN);
        return b;
    endfunction

    function automatic logic [7:0] pick_text();
        logic [7:0] b;
        do b = 8'($urandom_range(33, 255)); while (b == 8'h7f);
        return b;
    endfunction

    function automatic logic [7:0] pick_blank();
        return $urandom_range(0, 1) ? CHR_SPACE : CH_TAB;
    endfunction

    function automatic void gen_value();
        int r;
        repeat ($urandom_range(0, 10)) begin
            r = $urandom_range(0, 19);
            if (r < 14) push_byte(pick_token());
            else if (r < 17) push_byte(pick_text());
            else repeat ($urandom_range(1, 3)) push_byte(pick_blank());
        end
    endfunction

    function automatic void end_line(input bit corrupt);
        if (corrupt || $urandom_range(0, 1)) begin
            push_byte(CH_CR);
            if (corrupt) push_byte(8'($urandom_range(0, 255)));
        end
        push_byte(CH_LF);
    endfunction

    function automatic void gen_header(input bit corrupt);
        int spot;
        spot = corrupt ? $urandom_range(0, 2) : 3;
        repeat ($urandom_range(1, 8)) push_byte(pick_token());
        if (spot == 0) push_byte(8'($urandom_range(0, 255)));
        push_byte(CH_COLON);
        repeat ($urandom_range(0, 2)) push_byte(pick_blank());
        gen_value();
        if (spot == 1) push_byte(8'($urandom_range(0, 255)));
        end_line(spot == 2);
        if ($urandom_range(0, 4) == 0) begin
            push_byte(pick_blank());
            gen_value();
            end_line(1'b0);
        end
    endfunction

    function automatic void gen_block(input bit corrupt);
        int nh;
        int bad;
        nh  = $urandom_range(0, 5);
        bad = corrupt ? $urandom_range(0, nh) : -1;
        next_start = ($urandom_range(0, 9) != 0);
        for (int h = 0; h < nh; h++) begin
            gen_header(h == bad);
            if ($urandom_range(0, 7) == 0) push_cfg(16'($urandom_range(1, 64)));
        end
        end_line(bad == nh);
    endfunction

    function automatic void gen_noise();
        repeat ($urandom_range(1, 8)) begin
            next_start = ($urandom_range(0, 7) == 0);
            push_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void gen_crowded();
        next_start = 1'b1;
        repeat (int'(MAX_HEADERS) + 2) begin
            push_byte("k");
            push_byte(CH_COLON);
            push_byte("v");
            push_byte(CH_LF);
        end
    endfunction

    task automatic build_directed();
        logic [7:0] opening [20];
        opening = '{"A", "~", CH_COLON, CH_TAB, 8'h80, 8'hff, CHR_SPACE, "(", CH_COLON, CH_CR,
                    CH_LF, CHR_SPACE, "x", CH_LF, "B", CH_COLON, CH_LF, CH_CR, CH_LF, 8'h00};
        next_start = 1'b1;
        foreach (opening[i]) push_byte(opening[i]);
        next_start = 1'b1;
        push_byte(8'h00);
        push_byte(8'h7f);
        next_start = 1'b1;
        push_byte(CH_LF);
        push_cfg(16'd1);
        next_start = 1'b1;
        push_byte("a");
        push_byte(CH_COLON);
    endtask

    task automatic build_random();
        int r;
        bit crowded_done;
        crowded_done = 1'b0;
        while (byte_total < BYTE_TARGET) begin
            case ($urandom_range(0, 4))
                0: push_cfg(16'd1);
                1: push_cfg(16'hffff);
                2: push_cfg(MAX_BYTES_RST);
                3: push_cfg(16'($urandom_range(8, 80)));
                default: push_cfg(16'($urandom_range(1, 65535)));
            endcase
            if (byte_total > 300 && !crowded_done) begin
                push_cfg(16'hffff);
                gen_crowded();
                crowded_done = 1'b1;
            end
            repeat ($urandom_range(1, 4)) begin
                r = $urandom_range(0, 9);
                if (r == 0) gen_noise();
                else gen_block(r == 1);
            end
            if ($urandom_range(0, 2) == 0) push_drain();
        end
    endtask

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        t_pending nxt;
        bit took;
        bit go_byte;
        bit go_cfg;
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
            cfg_ch.valid  <= 1'b0;
        end else begin
            took = 1'b0;
            if (byte_ch.valid && byte_ch.ready) begin
                predict_byte(byte_ch.in_byte, byte_ch.start_req);
                took = 1'b1;
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                prs_cap = cfg_ch.max_bytes;
                took = 1'b1;
            end
            if (took) pend_q.delete(0);
            quiet_cycles = (token_q.size() == 0) ? quiet_cycles + 1 : 0;
            calm = (pend_q.size() < CALM_TAIL);
            if (took || !(byte_ch.valid || cfg_ch.valid)) begin
                go_byte = 1'b0;
                go_cfg  = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pend_q.size() > 0) begin
                    nxt = pend_q[0];
                    case (nxt.op)
                        OP_BYTE: begin
                            if (!calm && $urandom_range(0, 11) == 0) begin
                                gap_left = $urandom_range(0, 12);
                            end else begin
                                go_byte = 1'b1;
                                byte_ch.in_byte   <= nxt.data;
                                byte_ch.start_req <= nxt.start;
                            end
                        end
                        OP_CFG: begin
                            if (quiet_cycles >= 3) begin
                                go_cfg = 1'b1;
                                cfg_ch.max_bytes <= nxt.cap;
                            end
                        end
                        default: begin
                            if (quiet_cycles >= 3) pend_q.delete(0);
                        end
                    endcase
                end
                byte_ch.valid <= go_byte;
                cfg_ch.valid  <= go_cfg;
            end
        end
    end

    always @(posedge i_clk) begin
        t_token want;
        if (!i_rst_n) begin
            item_ch.ready <= 1'b0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                if (token_q.size() == 0) begin
                    $display("%0t: unexpected item, expected none actual kind %0d data %0h count %0d last %0b",
                             $time, item_ch.kind, item_ch.data_byte, item_ch.header_count,
                             item_ch.last);
                    errors++;
                end else begin
                    want = token_q.pop_front();
                    check_field("kind", want.kind, item_ch.kind);
                    check_field("data_byte", want.data, item_ch.data_byte);
                    check_field("header_count", want.hdr, item_ch.header_count);
                    check_field("last", want.last, item_ch.last);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                item_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 12);
                item_ch.ready <= 1'b0;
            end else begin
                item_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (byte_ch.valid && byte_ch.ready) || (item_ch.valid && item_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        byte_ch.valid     = 1'b0;
        byte_ch.in_byte   = 8'h00;
        byte_ch.start_req = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.max_bytes  = MAX_BYTES_RST;
        item_ch.ready     = 1'b0;
        build_directed();
        build_random();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pend_q.size() != 0 || token_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && token_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
